[src/bcdec_pkg.sv]
package bcdec_pkg;

   // Fixed field widths of the block word, the result beat and the registers.
   localparam int WORD_W      = 64;
   localparam int SIDE_W      = 15;
   localparam int COORD_W     = 14;
   localparam int CHAN_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int COLOR_IDX_W = 32;
   localparam int ALPHA_IDX_W = 48;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FORMAT_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   // Values of the format register.
   localparam logic FORMAT_BC1 = 1'b0;
   localparam logic FORMAT_BC3 = 1'b1;

   localparam logic [SIDE_W-1:0] RESET_SIDE = 15'd4;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type expand5_table_type [32];
   typedef chan_type expand6_table_type [64];

   // Everything the texel walk needs from one decoded block.
   typedef struct packed {
      logic                   mode;
      logic [3:0][CHAN_W-1:0] pal_r;
      logic [3:0][CHAN_W-1:0] pal_g;
      logic [3:0][CHAN_W-1:0] pal_b;
      logic [3:0][CHAN_W-1:0] pal_a;
      logic [7:0][CHAN_W-1:0] alpha_pal;
      logic [COLOR_IDX_W-1:0] color_idx;
      logic [ALPHA_IDX_W-1:0] alpha_idx;
      logic [1:0]             cols_m1;
      logic [1:0]             rows_m1;
      logic                   last_block;
   } block_type;

   // Expansion tables for the 5-bit and 6-bit channels, built at elaboration.
   function automatic expand5_table_type build_expand5();
      expand5_table_type tbl;
      for (int i = 0; i < 32; i++) begin
         tbl[i] = CHAN_W'((i * 255) / 31);
      end
      return tbl;
   endfunction

   function automatic expand6_table_type build_expand6();
      expand6_table_type tbl;
      for (int i = 0; i < 64; i++) begin
         tbl[i] = CHAN_W'((i * 255) / 63);
      end
      return tbl;
   endfunction

   localparam expand5_table_type EXPAND5_TABLE = build_expand5();
   localparam expand6_table_type EXPAND6_TABLE = build_expand6();

   // Floor division by 3 for sums up to 765, by reciprocal multiplication.
   function automatic chan_type div3(input logic [9:0] x);
      logic [19:0] prod;
      prod = 20'(x) * 20'd683;
      return prod[18:11];
   endfunction

   // Floor division by 5 for sums up to 1275.
   function automatic chan_type div5(input logic [10:0] x);
      logic [21:0] prod;
      prod = 22'(x) * 22'd1639;
      return prod[20:13];
   endfunction

   // Floor division by 7 for sums up to 1785.
   function automatic chan_type div7(input logic [10:0] x);
      logic [23:0] prod;
      prod = 24'(x) * 24'd4682;
      return prod[22:15];
   endfunction

   // Two thirds of a plus one third of b.
   function automatic chan_type blend_third(input chan_type a, input chan_type b);
      logic [9:0] sum;
      sum = 10'({a, 1'b0}) + 10'(b);
      return div3(sum);
   endfunction

   // Mean of two channels, rounded down.
   function automatic chan_type blend_half(input chan_type a, input chan_type b);
      logic [8:0] sum;
      sum = 9'(a) + 9'(b);
      return sum[8:1];
   endfunction

endpackage

[src/bc1_bc3_texture_block_decoder.sv]
// A color beat is loaded into the block register; its first texel then reaches rsp through the result register.
// Throughput: one texel per cycle while rsp_tready is high, set by the single-texel result
// register and the texel walk. The next color beat is taken in the cycle of the last texel;
// a BC3 alpha beat is taken during the previous block's walk, so in a steady stream it does
// not hold up the walk.
// Reset is synchronous: it selects BC1 and a 4x4 image, restarts at block 0,0 and
// empties the texel walk and the result register.
module bc1_bc3_texture_block_decoder #(
   parameter int MAX_IMAGE_SIDE = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] block_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [13:0] texel_x, [27:14] texel_y, [35:28] red, [43:36] green, [51:44] blue,
   // [59:52] alpha, [63:60] zero
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,   // last_texel
   output logic        rsp_tuser,   // image_done
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int MAX_COLS = (MAX_IMAGE_SIDE + 3) / 4;
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int POS_W    = (COL_W + 2 > bcdec_pkg::COORD_W) ? COL_W + 2 : bcdec_pkg::COORD_W;
   localparam int CMP_W    = bcdec_pkg::SIDE_W + 2;

   // Clamp a written size into 1 .. MAX_IMAGE_SIDE.
   function automatic logic [bcdec_pkg::SIDE_W-1:0] clamp_side(
      input logic [bcdec_pkg::SIDE_W-1:0] v);
      logic [bcdec_pkg::SIDE_W-1:0] r;
      if (v == '0) begin
         r = bcdec_pkg::SIDE_W'(1);
      end else if (CMP_W'(v) > CMP_W'(MAX_IMAGE_SIDE)) begin
         r = bcdec_pkg::SIDE_W'(MAX_IMAGE_SIDE);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Configuration and position state.
   logic                          format_mode_ff, format_mode_in;
   logic [bcdec_pkg::SIDE_W-1:0]  image_width_ff, image_width_in;
   logic [bcdec_pkg::SIDE_W-1:0]  image_height_ff, image_height_in;
   logic [COL_W-1:0]              block_column_ff, block_column_in;
   logic [COL_W-1:0]              block_row_ff, block_row_in;
   logic                          alpha_word_held_ff, alpha_word_held_in;
   logic [7:0]                    alpha_end_low_ff, alpha_end_low_in;
   logic [7:0]                    alpha_end_high_ff, alpha_end_high_in;
   logic [bcdec_pkg::ALPHA_IDX_W-1:0] alpha_index_bits_ff, alpha_index_bits_in;

   // Block register and texel walk.
   bcdec_pkg::block_type          block_ff, block_in;
   logic [COL_W-1:0]              base_col_ff, base_col_in;
   logic [COL_W-1:0]              base_row_ff, base_row_in;
   logic                          busy_ff, busy_in;
   logic [1:0]                    cx_ff, cx_in;
   logic [1:0]                    ry_ff, ry_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [63:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_done_ff, rsp_done_in;

   logic alpha_phase, req_fire, color_fire, alpha_fire;
   logic emit_fire, texel_last, finishing;
   logic col_last, row_last;
   logic [13:0] num_cols, num_rows;
   logic [CMP_W-1:0] rem_x, rem_y;
   logic [1:0] vis_cols_m1, vis_rows_m1;

   // Handshake decisions.
   assign alpha_phase = (format_mode_ff == bcdec_pkg::FORMAT_BC3) && !alpha_word_held_ff;
   assign emit_fire   = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign texel_last  = (cx_ff == block_ff.cols_m1) && (ry_ff == block_ff.rows_m1);
   assign finishing   = emit_fire && texel_last;
   assign req_tready  = alpha_phase || !busy_ff || finishing;
   assign req_fire    = req_tvalid && req_tready;
   assign color_fire  = req_fire && !alpha_phase;
   assign alpha_fire  = req_fire && alpha_phase;

   // Block grid and the visible part of the current block.
   always_comb begin
      num_cols = 14'((17'(image_width_ff) + 17'd3) >> 2);
      num_rows = 14'((17'(image_height_ff) + 17'd3) >> 2);
      col_last = (CMP_W'(block_column_ff) + CMP_W'(1)) >= CMP_W'(num_cols);
      row_last = (CMP_W'(block_row_ff) + CMP_W'(1)) >= CMP_W'(num_rows);
      rem_x = CMP_W'(image_width_ff) - CMP_W'(1) - CMP_W'({block_column_ff, 2'b00});
      rem_y = CMP_W'(image_height_ff) - CMP_W'(1) - CMP_W'({block_row_ff, 2'b00});
      vis_cols_m1 = (rem_x > CMP_W'(3)) ? 2'd3 : rem_x[1:0];
      vis_rows_m1 = (rem_y > CMP_W'(3)) ? 2'd3 : rem_y[1:0];
   end

   // Palettes of the incoming color word and of the held alpha endpoints.
   bcdec_pkg::chan_type er [2];
   bcdec_pkg::chan_type eg [2];
   bcdec_pkg::chan_type eb [2];
   logic [15:0] c0, c1;
   logic [10:0] alpha_sum;

   always_comb begin
      c0 = req_tdata[15:0];
      c1 = req_tdata[31:16];
      er[0] = bcdec_pkg::EXPAND5_TABLE[c0[15:11]];
      eg[0] = bcdec_pkg::EXPAND6_TABLE[c0[10:5]];
      eb[0] = bcdec_pkg::EXPAND5_TABLE[c0[4:0]];
      er[1] = bcdec_pkg::EXPAND5_TABLE[c1[15:11]];
      eg[1] = bcdec_pkg::EXPAND6_TABLE[c1[10:5]];
      eb[1] = bcdec_pkg::EXPAND5_TABLE[c1[4:0]];

      block_in = block_ff;
      block_in.mode = format_mode_ff;
      block_in.pal_r[0] = er[0];
      block_in.pal_g[0] = eg[0];
      block_in.pal_b[0] = eb[0];
      block_in.pal_r[1] = er[1];
      block_in.pal_g[1] = eg[1];
      block_in.pal_b[1] = eb[1];
      block_in.pal_a = {4{bcdec_pkg::CHAN_MAX}};
      if (c0 > c1) begin
         block_in.pal_r[2] = bcdec_pkg::blend_third(er[0], er[1]);
         block_in.pal_g[2] = bcdec_pkg::blend_third(eg[0], eg[1]);
         block_in.pal_b[2] = bcdec_pkg::blend_third(eb[0], eb[1]);
         block_in.pal_r[3] = bcdec_pkg::blend_third(er[1], er[0]);
         block_in.pal_g[3] = bcdec_pkg::blend_third(eg[1], eg[0]);
         block_in.pal_b[3] = bcdec_pkg::blend_third(eb[1], eb[0]);
      end else begin
         // Three-color mode: entry three is transparent black.
         block_in.pal_r[2] = bcdec_pkg::blend_half(er[0], er[1]);
         block_in.pal_g[2] = bcdec_pkg::blend_half(eg[0], eg[1]);
         block_in.pal_b[2] = bcdec_pkg::blend_half(eb[0], eb[1]);
         block_in.pal_r[3] = '0;
         block_in.pal_g[3] = '0;
         block_in.pal_b[3] = '0;
         block_in.pal_a[3] = '0;
      end

      // Alpha palette: six interpolated steps, or four plus fixed 0 and 255.
      block_in.alpha_pal[0] = alpha_end_low_ff;
      block_in.alpha_pal[1] = alpha_end_high_ff;
      alpha_sum = '0;
      if (alpha_end_low_ff > alpha_end_high_ff) begin
         for (int k = 2; k < 8; k++) begin
            alpha_sum = 11'(8 - k) * 11'(alpha_end_low_ff)
                      + 11'(k - 1) * 11'(alpha_end_high_ff);
            block_in.alpha_pal[k] = bcdec_pkg::div7(alpha_sum);
         end
      end else begin
         for (int k = 2; k < 6; k++) begin
            alpha_sum = 11'(6 - k) * 11'(alpha_end_low_ff)
                      + 11'(k - 1) * 11'(alpha_end_high_ff);
            block_in.alpha_pal[k] = bcdec_pkg::div5(alpha_sum);
         end
         block_in.alpha_pal[6] = '0;
         block_in.alpha_pal[7] = bcdec_pkg::CHAN_MAX;
      end

      block_in.color_idx  = req_tdata[63:32];
      block_in.alpha_idx  = alpha_index_bits_ff;
      block_in.cols_m1    = vis_cols_m1;
      block_in.rows_m1    = vis_rows_m1;
      block_in.last_block = col_last && row_last;
   end

   // Register writes, block position and the alpha word hold.
   logic csr_hit;

   always_comb begin
      format_mode_in      = format_mode_ff;
      image_width_in      = image_width_ff;
      image_height_in     = image_height_ff;
      block_column_in     = block_column_ff;
      block_row_in        = block_row_ff;
      alpha_word_held_in  = alpha_word_held_ff;
      alpha_end_low_in    = alpha_end_low_ff;
      alpha_end_high_in   = alpha_end_high_ff;
      alpha_index_bits_in = alpha_index_bits_ff;
      csr_hit             = 1'b1;

      if (alpha_fire) begin
         alpha_end_low_in    = req_tdata[7:0];
         alpha_end_high_in   = req_tdata[15:8];
         alpha_index_bits_in = req_tdata[63:16];
      end

      if (csr_we) begin
         case (csr_index)
            bcdec_pkg::CSR_FORMAT_MODE:  format_mode_in  = csr_wdata[0];
            bcdec_pkg::CSR_IMAGE_WIDTH:  image_width_in  = clamp_side(csr_wdata);
            bcdec_pkg::CSR_IMAGE_HEIGHT: image_height_in = clamp_side(csr_wdata);
            default:                     csr_hit         = 1'b0;
         endcase
         if (csr_hit) begin
            block_column_in    = '0;
            block_row_in       = '0;
            alpha_word_held_in = 1'b0;
         end
      end else if (color_fire) begin
         if (col_last) begin
            block_column_in = '0;
            block_row_in    = row_last ? '0 : block_row_ff + COL_W'(1);
         end else begin
            block_column_in = block_column_ff + COL_W'(1);
         end
         alpha_word_held_in = 1'b0;
      end else if (alpha_fire) begin
         alpha_word_held_in = 1'b1;
      end
   end

   // Texel walk over the visible rows and columns, one texel per beat.
   logic [3:0] texel_num;
   logic [1:0] ci;
   logic [2:0] ai;
   logic [POS_W-1:0] x_wide, y_wide;
   logic [7:0] alpha_out;

   always_comb begin
      base_col_in = color_fire ? block_column_ff : base_col_ff;
      base_row_in = color_fire ? block_row_ff : base_row_ff;
      busy_in = busy_ff;
      cx_in   = cx_ff;
      ry_in   = ry_ff;
      if (emit_fire) begin
         if (texel_last) begin
            busy_in = 1'b0;
         end else if (cx_ff == block_ff.cols_m1) begin
            cx_in = '0;
            ry_in = ry_ff + 2'd1;
         end else begin
            cx_in = cx_ff + 2'd1;
         end
      end
      if (color_fire) begin
         busy_in = 1'b1;
         cx_in   = '0;
         ry_in   = '0;
      end

      // Index bits follow the texel's place in the whole block.
      texel_num = {ry_ff, cx_ff};
      ci = block_ff.color_idx[{texel_num, 1'b0} +: 2];
      ai = block_ff.alpha_idx[6'(texel_num) * 6'd3 +: 3];
      x_wide = POS_W'({base_col_ff, cx_ff});
      y_wide = POS_W'({base_row_ff, ry_ff});
      alpha_out = (block_ff.mode == bcdec_pkg::FORMAT_BC3) ? block_ff.alpha_pal[ai]
                                                           : block_ff.pal_a[ci];

      rsp_valid_in = emit_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (emit_fire) begin
         rsp_data_in = {4'b0000, alpha_out, block_ff.pal_b[ci], block_ff.pal_g[ci],
                        block_ff.pal_r[ci], y_wide[13:0], x_wide[13:0]};
         rsp_last_in = texel_last;
         rsp_done_in = texel_last && block_ff.last_block;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_ff      <= bcdec_pkg::FORMAT_BC1;
         image_width_ff      <= bcdec_pkg::RESET_SIDE;
         image_height_ff     <= bcdec_pkg::RESET_SIDE;
         block_column_ff     <= '0;
         block_row_ff        <= '0;
         alpha_word_held_ff  <= 1'b0;
         alpha_end_low_ff    <= '0;
         alpha_end_high_ff   <= '0;
         alpha_index_bits_ff <= '0;
         busy_ff             <= 1'b0;
         cx_ff               <= '0;
         ry_ff               <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         format_mode_ff      <= format_mode_in;
         image_width_ff      <= image_width_in;
         image_height_ff     <= image_height_in;
         block_column_ff     <= block_column_in;
         block_row_ff        <= block_row_in;
         alpha_word_held_ff  <= alpha_word_held_in;
         alpha_end_low_ff    <= alpha_end_low_in;
         alpha_end_high_ff   <= alpha_end_high_in;
         alpha_index_bits_ff <= alpha_index_bits_in;
         busy_ff             <= busy_in;
         cx_ff               <= cx_in;
         ry_ff               <= ry_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (color_fire) begin
         block_ff <= block_in;
      end
      base_col_ff <= base_col_in;
      base_row_ff <= base_row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   // The walk never leaves the visible part of its block.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cx_ff <= block_ff.cols_m1) && (ry_ff <= block_ff.rows_m1))
      else $error("texel walk outside the visible block");

   // The end of the image is flagged only on a block's last texel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("image end flagged on an inner texel");

   // A finished block with no successor leaves the walk idle.
   assert property (@(posedge clock) disable iff (reset)
      (finishing && !color_fire) |=> !busy_ff)
      else $error("walk still busy after its last texel");

   // An alpha beat in BC3 mode is held for the following color beat.
   assert property (@(posedge clock) disable iff (reset)
      (alpha_fire && !csr_we) |=> alpha_word_held_ff)
      else $error("alpha beat not held");

   // Reset empties the walk and the result register.
   assert property (@(posedge clock)
      reset |=> (!busy_ff && !rsp_valid_ff))
      else $error("reset left work in flight");

endmodule

[verif/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SIDE = 16384;
   // The register index that maps to no register; a write there must be ignored.
   localparam logic [bcdec_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // One decoded texel as the result port should present it.
   typedef struct {
      logic [bcdec_pkg::COORD_W-1:0] x;
      logic [bcdec_pkg::COORD_W-1:0] y;
      logic [bcdec_pkg::CHAN_W-1:0]  r;
      logic [bcdec_pkg::CHAN_W-1:0]  g;
      logic [bcdec_pkg::CHAN_W-1:0]  b;
      logic [bcdec_pkg::CHAN_W-1:0]  a;
      logic                          last;
      logic                          done;
   } texel_type;

   // Decodes every accepted block word into the texels it must produce and
   // checks the texel beats against them in order.
   class texel_checker;
      logic               mode;
      int                 width;
      int                 height;
      int                 block_col;
      int                 block_row;
      bit                 alpha_held;
      int                 alpha_lo;
      int                 alpha_hi;
      logic [47:0]        alpha_bits;
      texel_type          expected_texels[$];
      int                 failures;

      function new();
         mode       = bcdec_pkg::FORMAT_BC1;
         width      = bcdec_pkg::RESET_SIDE;
         height     = bcdec_pkg::RESET_SIDE;
         alpha_lo   = 0;
         alpha_hi   = 0;
         alpha_bits = '0;
         failures   = 0;
         restart();
      endfunction

      function void restart();
         block_col  = 0;
         block_row  = 0;
         alpha_held = 0;
      endfunction

      // Sizes outside the legal range are pulled back to it.
      function int clamp_side(logic [bcdec_pkg::SIDE_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_SIDE) return MAX_SIDE;
         return v;
      endfunction

      function void note_write(logic [bcdec_pkg::CSR_INDEX_W-1:0] idx,
                               logic [bcdec_pkg::SIDE_W-1:0] value);
         case (idx)
            bcdec_pkg::CSR_FORMAT_MODE:  mode = value[0];
            bcdec_pkg::CSR_IMAGE_WIDTH:  width = clamp_side(value);
            bcdec_pkg::CSR_IMAGE_HEIGHT: height = clamp_side(value);
            default:                     return;
         endcase
         restart();
      endfunction

      function void take_block(logic [bcdec_pkg::WORD_W-1:0] w);
         int          pr[4], pg[4], pb[4], pa[4], at[8];
         int          c0, c1, ci, ai, x, y, cols, rows;
         bit          last_block;
         logic [31:0] cidx;
         texel_type   tx;
         texel_type   blk[$];

         // In BC3 the first word of a pair only loads the alpha block.
         if (mode == bcdec_pkg::FORMAT_BC3 && !alpha_held) begin
            alpha_lo   = w[7:0];
            alpha_hi   = w[15:8];
            alpha_bits = w[63:16];
            alpha_held = 1;
            return;
         end

         c0   = w[15:0];
         c1   = w[31:16];
         cidx = w[63:32];

         // Endpoint expansion from RGB565.
         pr[0] = ((c0 >> 11) & 31) * 255 / 31;
         pg[0] = ((c0 >> 5) & 63) * 255 / 63;
         pb[0] = (c0 & 31) * 255 / 31;
         pr[1] = ((c1 >> 11) & 31) * 255 / 31;
         pg[1] = ((c1 >> 5) & 63) * 255 / 63;
         pb[1] = (c1 & 31) * 255 / 31;
         pa[0] = 255;
         pa[1] = 255;
         pa[2] = 255;
         if (c0 > c1) begin
            pr[2] = (2 * pr[0] + pr[1]) / 3;
            pg[2] = (2 * pg[0] + pg[1]) / 3;
            pb[2] = (2 * pb[0] + pb[1]) / 3;
            pr[3] = (pr[0] + 2 * pr[1]) / 3;
            pg[3] = (pg[0] + 2 * pg[1]) / 3;
            pb[3] = (pb[0] + 2 * pb[1]) / 3;
            pa[3] = 255;
         end else begin
            pr[2] = (pr[0] + pr[1]) / 2;
            pg[2] = (pg[0] + pg[1]) / 2;
            pb[2] = (pb[0] + pb[1]) / 2;
            pr[3] = 0;
            pg[3] = 0;
            pb[3] = 0;
            pa[3] = 0;
         end

         // Alpha palette, eight-step or six-step with fixed black and white.
         at[0] = alpha_lo;
         at[1] = alpha_hi;
         if (alpha_lo > alpha_hi) begin
            for (int k = 2; k < 8; k++)
               at[k] = ((8 - k) * alpha_lo + (k - 1) * alpha_hi) / 7;
         end else begin
            for (int k = 2; k < 6; k++)
               at[k] = ((6 - k) * alpha_lo + (k - 1) * alpha_hi) / 5;
            at[6] = 0;
            at[7] = 255;
         end

         cols = (width + 3) / 4;
         rows = (height + 3) / 4;
         last_block = (block_col + 1 >= cols) && (block_row + 1 >= rows);

         // Raster walk; clipped texels still use up their index bits.
         for (int t = 0; t < 16; t++) begin
            ci = (cidx >> (2 * t)) & 3;
            ai = (alpha_bits >> (3 * t)) & 7;
            x  = block_col * 4 + (t % 4);
            y  = block_row * 4 + (t / 4);
            if (x >= width || y >= height) continue;
            tx.x    = bcdec_pkg::COORD_W'(x);
            tx.y    = bcdec_pkg::COORD_W'(y);
            tx.r    = bcdec_pkg::CHAN_W'(pr[ci]);
            tx.g    = bcdec_pkg::CHAN_W'(pg[ci]);
            tx.b    = bcdec_pkg::CHAN_W'(pb[ci]);
            tx.a    = (mode == bcdec_pkg::FORMAT_BC3) ? bcdec_pkg::CHAN_W'(at[ai])
                                                      : bcdec_pkg::CHAN_W'(pa[ci]);
            tx.last = 1'b0;
            tx.done = 1'b0;
            blk.insert(blk.size(), tx);
         end
         if (blk.size() > 0) begin
            blk[blk.size() - 1].last = 1'b1;
            blk[blk.size() - 1].done = last_block;
         end
         foreach (blk[i]) expected_texels.insert(expected_texels.size(), blk[i]);

         // Column first, then row, wrapping at the end of the image.
         if (block_col + 1 >= cols) begin
            block_col = 0;
            block_row = (block_row + 1 >= rows) ? 0 : block_row + 1;
         end else begin
            block_col++;
         end
         alpha_held = 0;
      endfunction

      function int pending();
         return expected_texels.size();
      endfunction

      function void compare(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_texel(logic [63:0] d, logic tl, logic tu);
         texel_type e;
         if (expected_texels.size() == 0) begin
            $error("texel beat x=%0d y=%0d with nothing expected", d[13:0], d[27:14]);
            failures++;
            return;
         end
         e = expected_texels.pop_front();
         compare("texel_x", e.x, d[13:0]);
         compare("texel_y", e.y, d[27:14]);
         compare("red", e.r, d[35:28]);
         compare("green", e.g, d[43:36]);
         compare("blue", e.b, d[51:44]);
         compare("alpha", e.a, d[59:52]);
         compare("pad", '0, d[63:60]);
         compare("last_texel", e.last, tl);
         compare("image_done", e.done, tu);
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bcdec_pkg::WORD_W-1:0]      req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [63:0]                       rsp_tdata;
   logic                              rsp_tlast;
   logic                              rsp_tuser;
   logic                              csr_we = 1'b0;
   logic [bcdec_pkg::CSR_INDEX_W-1:0] csr_index = bcdec_pkg::CSR_FORMAT_MODE;
   logic [bcdec_pkg::SIDE_W-1:0]      csr_wdata = '0;
   bit                                calm = 1'b0;

   texel_checker board = new();

   bc1_bc3_texture_block_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Random idle decision shared by both sides, switched off during a calm stretch.
   function automatic bit take_break();
      return !calm && ($urandom_range(99) < 18);
   endfunction

   // Random block word, often with equal or swapped endpoints.
   function automatic logic [bcdec_pkg::WORD_W-1:0] random_word();
      logic [bcdec_pkg::WORD_W-1:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(3))
         1:       w[31:0] = {w[15:0], w[31:16]};
         2:       w[31:16] = w[15:0];
         3:       w[15:8] = w[7:0];
         default: ;
      endcase
      return w;
   endfunction

   // Alpha index field that walks through all eight palette entries twice.
   function automatic logic [bcdec_pkg::ALPHA_IDX_W-1:0] alpha_ramp();
      logic [bcdec_pkg::ALPHA_IDX_W-1:0] r;
      for (int t = 0; t < 16; t++) r[3 * t +: 3] = 3'(t);
      return r;
   endfunction

   // Mostly small images, with out-of-range and full-size sides now and then.
   function automatic logic [bcdec_pkg::SIDE_W-1:0] pick_side();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return bcdec_pkg::SIDE_W'($urandom_range(20, 1));
      if (roll < 80) return bcdec_pkg::SIDE_W'($urandom_range(64, 21));
      if (roll < 85) return '0;
      if (roll < 90) return bcdec_pkg::SIDE_W'($urandom_range(32767, MAX_SIDE + 1));
      if (roll < 95) return bcdec_pkg::SIDE_W'(MAX_SIDE);
      return bcdec_pkg::SIDE_W'($urandom_range(MAX_SIDE, 1));
   endfunction

   // Offer one block word and wait for its beat to be taken.
   task automatic send_word(input logic [bcdec_pkg::WORD_W-1:0] w);
      if (take_break()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (take_break()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      board.take_block(w);
   endtask

   // Stop sending, wait for every expected texel, then let the pipeline drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bcdec_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bcdec_pkg::SIDE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.note_write(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: check each texel beat and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         board.check_texel(rsp_tdata, rsp_tlast, rsp_tuser);
      rsp_tready <= !take_break();
   end

   initial begin
      logic [bcdec_pkg::SIDE_W-1:0] w_side;
      logic [bcdec_pkg::SIDE_W-1:0] h_side;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // BC1 at the reset size: both palette modes, equal endpoints, all-zero and all-one words.
      send_word(64'hE4E4_E4E4_0000_FFFF);
      send_word(64'h1B1B_1B1B_FFFF_0000);
      send_word(64'hFFFF_FFFF_1234_1234);
      send_word('0);
      send_word('1);
      send_word(64'h9C9C_3636_F81F_07E0);
      settle();

      // BC3 pairs covering both alpha palette modes and every alpha index.
      write_csr(bcdec_pkg::CSR_FORMAT_MODE, bcdec_pkg::SIDE_W'(bcdec_pkg::FORMAT_BC3));
      send_word({alpha_ramp(), 8'h00, 8'hFF});
      send_word(64'hE4E4_E4E4_001F_F800);
      send_word({alpha_ramp(), 8'hF0, 8'h10});
      send_word(random_word());
      send_word({alpha_ramp(), 8'h80, 8'h80});
      send_word(64'h1B1B_1B1B_07E0_F81F);
      send_word('1);
      send_word('0);
      send_word({~alpha_ramp(), 8'h00, 8'h00});
      send_word(random_word());

      // A held alpha word must be dropped by a register write.
      send_word({alpha_ramp(), 8'h01, 8'hFE});
      settle();
      write_csr(bcdec_pkg::CSR_IMAGE_WIDTH, 15'd6);
      write_csr(bcdec_pkg::CSR_IMAGE_HEIGHT, 15'd7);
      send_word({alpha_ramp(), 8'h40, 8'hC0});
      send_word(random_word());
      settle();

      // Clipped BC1 image, restarted midway, then run to its wrap.
      write_csr(bcdec_pkg::CSR_FORMAT_MODE, bcdec_pkg::SIDE_W'(bcdec_pkg::FORMAT_BC1));
      send_word(random_word());
      send_word(random_word());
      settle();
      write_csr(bcdec_pkg::CSR_IMAGE_WIDTH, 15'd6);
      repeat (4) send_word(random_word());
      settle();

      // Random phases over modes and image sizes.
      for (int phase = 0; phase < 12; phase++) begin
         calm = (phase == 5);
         w_side = pick_side();
         h_side = pick_side();
         if (phase == 0) begin
            w_side = 15'd1;
            h_side = 15'd1;
         end else if (phase == 1) begin
            w_side = '0;
            h_side = 15'h7FFF;
         end
         write_csr(bcdec_pkg::CSR_FORMAT_MODE, bcdec_pkg::SIDE_W'($urandom_range(1)));
         write_csr(bcdec_pkg::CSR_IMAGE_WIDTH, w_side);
         write_csr(bcdec_pkg::CSR_IMAGE_HEIGHT, h_side);
         if (phase % 4 == 3) write_csr(CSR_UNUSED, bcdec_pkg::SIDE_W'($urandom));
         repeat (28) send_word(random_word());
         settle();
      end
      calm = 1'b0;

      if (board.failures == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2ms;
      $display("testbench: errors");
      $finish;
   end

endmodule
